[design/pfa_pkg.sv]
`timescale 1ns / 1ps

package pfa_pkg;

  // default sizing
  localparam int unsigned PAGE_CNT_DEF  = 4096;
  localparam int unsigned REF_WIDTH_DEF = 16;

  // fixed field widths
  localparam int unsigned OP_W     = 3;
  localparam int unsigned PAGE_W   = 12;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned REF_OUT_W = 16;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 1'b1;

  // register reset values
  localparam logic [CFG_W-1:0] RESERVED_RST = 13'd1;
  localparam logic [CFG_W-1:0] TOTAL_RST    = 13'd4096;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC      = 3'd0,
    OP_ALLOC_MANY = 3'd1,
    OP_FREE       = 3'd2,
    OP_INC_REF    = 3'd3,
    OP_DEC_REF    = 3'd4,
    OP_GET_REF    = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_PARTIAL   = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_e;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [PAGE_W-1:0]  page_index;
    logic [COUNT_W-1:0] page_count;
  } req_t;

  typedef struct packed {
    logic [PAGE_W-1:0]    result_page;
    logic [REF_OUT_W-1:0] ref_value;
    status_e              status;
  } rsp_t;

endpackage

[design/page_frame_free_list_allocator_top.sv]
`timescale 1ns / 1ps
// Sequencing: alloc one passes through S_MANY and free/ref requests through S_REF before the
// registered done_o strobe; alloc many of n>0 pages stays in S_MANY for up to n pops; an empty
// list, out-of-range page or unused code strobes done_o in the cycle after accept. A new
// request can be taken in the cycle done_o is high; pops follow the registered link read
// (one pop per cycle once started). Reset and each config write sweep all PAGE_CNT entries
// of both memories with busy_o high; results are strobed for one cycle and cannot be stalled.
module page_frame_free_list_allocator_top #(
  parameter int unsigned PAGE_CNT  = pfa_pkg::PAGE_CNT_DEF,
  parameter int unsigned REF_WIDTH = pfa_pkg::REF_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  pfa_pkg::req_t                  req_i,
  output logic                           busy_o,
  output logic                           done_o,
  output pfa_pkg::rsp_t                  rsp_o,
  input  logic                           cfg_we_i,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pfa_pkg::CFG_W-1:0]      cfg_data_i
);
  import pfa_pkg::*;

  localparam int unsigned AW = $clog2(PAGE_CNT);
  localparam int unsigned LW = $clog2(PAGE_CNT + 1);
  localparam int unsigned CW = (LW > CFG_W) ? LW : CFG_W;
  localparam logic [LW-1:0] NIL = LW'(PAGE_CNT);

  typedef enum logic [4:0] {
    S_INIT = 5'b00001,
    S_IDLE = 5'b00010,
    S_MANY = 5'b00100,
    S_PEEK = 5'b01000,
    S_REF  = 5'b10000
  } state_e;

  function automatic logic [LW-1:0] clamp_cfg(input logic [CFG_W-1:0] v);
    logic [CW-1:0] w;
    w = CW'(v);
    if (w > CW'(PAGE_CNT)) return NIL;
    return LW'(w);
  endfunction

  function automatic rsp_t mk_rsp(input logic [PAGE_W-1:0] p, input logic [REF_OUT_W-1:0] v,
                                  input status_e s);
    rsp_t r;
    r.result_page = p;
    r.ref_value   = v;
    r.status      = s;
    return r;
  endfunction

  state_e             state_q, state_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [LW-1:0]      head_q, head_d;
  logic [LW-1:0]      first_q, first_d;
  logic [COUNT_W-1:0] rem_q, rem_d;
  logic [OP_W-1:0]    op_q, op_d;
  logic [PAGE_W-1:0]  page_q, page_d;
  logic [CFG_W-1:0]   cfg_res_q, cfg_res_d;
  logic [CFG_W-1:0]   cfg_top_q, cfg_top_d;
  rsp_t               rsp_q, rsp_d;
  logic               done_q, done_d;

  // memory ports
  logic               lnk_we;
  logic [AW-1:0]      lnk_wa, lnk_ra;
  logic [LW-1:0]      lnk_wd, lnk_rd_q;
  logic               cnt_we;
  logic [AW-1:0]      cnt_wa, cnt_ra;
  logic [REF_WIDTH-1:0] cnt_wd, cnt_rd_q;

  logic [LW-1:0]      res_c, top_c, lnk_next;
  logic               head_null, page_ok, is_alloc;
  logic [REF_WIDTH-1:0] cnt_v;
  status_e            st_v;

  assign res_c     = clamp_cfg(cfg_res_q);
  assign top_c     = clamp_cfg(cfg_top_q);
  assign head_null = (head_q >= NIL);
  assign lnk_next  = (lnk_rd_q > NIL) ? NIL : lnk_rd_q;
  assign page_ok   = (CW'(req_i.page_index) < CW'(PAGE_CNT));
  assign is_alloc  = (req_i.operation == OP_ALLOC) || (req_i.operation == OP_ALLOC_MANY);

  // link store, one write and one registered read per cycle
  logic [LW-1:0] lnk_mem [PAGE_CNT];
  always_ff @(posedge clk_i) begin
    if (lnk_we) begin
      lnk_mem[lnk_wa] <= lnk_wd;
    end
    lnk_rd_q <= lnk_mem[lnk_ra];
  end

  // reference count store
  logic [REF_WIDTH-1:0] cnt_mem [PAGE_CNT];
  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_rd_q <= cnt_mem[cnt_ra];
  end

  // control and sequencing
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    head_d    = head_q;
    first_d   = first_q;
    rem_d     = rem_q;
    op_d      = op_q;
    page_d    = page_q;
    cfg_res_d = cfg_res_q;
    cfg_top_d = cfg_top_q;
    rsp_d     = rsp_q;
    done_d    = 1'b0;
    lnk_we    = 1'b0;
    lnk_wa    = idx_q;
    lnk_wd    = NIL;
    lnk_ra    = AW'(head_q);
    cnt_we    = 1'b0;
    cnt_wa    = idx_q;
    cnt_wd    = '0;
    cnt_ra    = is_alloc ? AW'(head_q) : AW'(req_i.page_index);
    cnt_v     = cnt_rd_q;
    st_v      = ST_OK;

    case (state_q)
      // rebuild sweep: chain free pages in order, mark reserved ones in use
      S_INIT: begin
        lnk_we = 1'b1;
        lnk_wa = idx_q;
        if ((LW'(idx_q) >= res_c) && ((LW + 1)'(idx_q) + 1'b1 < (LW + 1)'(top_c))) begin
          lnk_wd = LW'(idx_q) + 1'b1;
        end
        cnt_we = 1'b1;
        cnt_wa = idx_q;
        cnt_wd = (LW'(idx_q) < res_c) ? REF_WIDTH'(1) : '0;
        head_d = (res_c < top_c) ? res_c : NIL;
        if (idx_q == AW'(PAGE_CNT - 1)) begin
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      // take a request
      S_IDLE: begin
        if (start_i) begin
          op_d   = req_i.operation;
          page_d = req_i.page_index;
          case (req_i.operation)
            OP_ALLOC, OP_ALLOC_MANY: begin
              if (head_null) begin
                rsp_d  = mk_rsp('0, '0, ST_EMPTY);
                done_d = 1'b1;
              end else if ((req_i.operation == OP_ALLOC_MANY) && (req_i.page_count == '0)) begin
                state_d = S_PEEK;
              end else begin
                // first pop: link read issued at head, count set now
                cnt_we  = 1'b1;
                cnt_wa  = AW'(head_q);
                cnt_wd  = REF_WIDTH'(1);
                first_d = head_q;
                rem_d   = (req_i.operation == OP_ALLOC) ? COUNT_W'(1) : req_i.page_count;
                state_d = S_MANY;
              end
            end
            OP_FREE, OP_INC_REF, OP_DEC_REF, OP_GET_REF: begin
              if (page_ok) begin
                state_d = S_REF;
              end else begin
                rsp_d  = mk_rsp(req_i.page_index, '0, ST_OK);
                done_d = 1'b1;
              end
            end
            default: begin
              rsp_d  = mk_rsp(req_i.page_index, '0, ST_OK);
              done_d = 1'b1;
            end
          endcase
        end
      end

      // pop loop: link data arrives, advance head, start next pop
      S_MANY: begin
        head_d = lnk_next;
        rem_d  = rem_q - 1'b1;
        if (rem_q == COUNT_W'(1)) begin
          rsp_d   = mk_rsp(PAGE_W'(first_q), REF_OUT_W'(1), ST_OK);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (lnk_next >= NIL) begin
          rsp_d   = mk_rsp(PAGE_W'(first_q), REF_OUT_W'(1), ST_PARTIAL);
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          cnt_we = 1'b1;
          cnt_wa = AW'(lnk_next);
          cnt_wd = REF_WIDTH'(1);
          lnk_ra = AW'(lnk_next);
        end
      end

      // alloc many of zero pages: report head and its count
      S_PEEK: begin
        rsp_d   = mk_rsp(PAGE_W'(head_q), REF_OUT_W'(cnt_rd_q), ST_OK);
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      // count read-modify-write, free also pushes onto the head
      S_REF: begin
        case (op_q)
          OP_FREE: begin
            lnk_we = 1'b1;
            lnk_wa = AW'(page_q);
            lnk_wd = head_q;
            head_d = LW'(page_q);
            if (cnt_rd_q == '0) begin
              st_v = ST_UNDERFLOW;
            end else begin
              cnt_v = cnt_rd_q - 1'b1;
            end
          end
          OP_INC_REF: begin
            if (cnt_rd_q != '1) begin
              cnt_v = cnt_rd_q + 1'b1;
            end
          end
          OP_DEC_REF: begin
            if (cnt_rd_q == '0) begin
              st_v = ST_UNDERFLOW;
            end else begin
              cnt_v = cnt_rd_q - 1'b1;
            end
          end
          default: begin
          end
        endcase
        cnt_we  = 1'b1;
        cnt_wa  = AW'(page_q);
        cnt_wd  = cnt_v;
        rsp_d   = mk_rsp(page_q, REF_OUT_W'(cnt_v), st_v);
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_INIT;
        idx_d   = '0;
      end
    endcase

    // register write restarts the rebuild sweep
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RESERVED: cfg_res_d = cfg_data_i;
        CFG_TOTAL:    cfg_top_d = cfg_data_i;
        default: begin
        end
      endcase
      state_d = S_INIT;
      idx_d   = '0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_INIT;
      idx_q     <= '0;
      head_q    <= NIL;
      cfg_res_q <= RESERVED_RST;
      cfg_top_q <= TOTAL_RST;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      head_q    <= head_d;
      cfg_res_q <= cfg_res_d;
      cfg_top_q <= cfg_top_d;
      done_q    <= done_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    first_q <= first_d;
    rem_q   <= rem_d;
    op_q    <= op_d;
    page_q  <= page_d;
    rsp_q   <= rsp_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

[test/free_list_checker.sv]
`timescale 1ns / 1ps

module free_list_checker
  import pfa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  req_t                 req_i,
  input  logic                 busy_o,
  input  logic                 done_o,
  input  rsp_t                 rsp_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   pending_o,
  output int                   fail_count_o
);

  localparam logic [CFG_W-1:0]     NO_PAGE  = CFG_W'(PAGE_CNT_DEF);
  localparam logic [REF_OUT_W-1:0] REF_CEIL = '1;
  localparam int                   MAX_SHOWN = 10;

  // shadow allocator state
  logic [CFG_W-1:0]     reserved_cfg;
  logic [CFG_W-1:0]     total_cfg;
  logic [CFG_W-1:0]     list_head;
  logic [CFG_W-1:0]     link_of [PAGE_CNT_DEF];
  logic [REF_OUT_W-1:0] refs_of [PAGE_CNT_DEF];

  rsp_t expected_q[$];
  int   mismatches = 0;

  // low pages held, the rest below the total chained in ascending order
  function automatic void rebuild_pool();
    int unsigned lo;
    int unsigned hi;
    int unsigned i;
    lo = (reserved_cfg > PAGE_CNT_DEF) ? PAGE_CNT_DEF : reserved_cfg;
    hi = (total_cfg > PAGE_CNT_DEF) ? PAGE_CNT_DEF : total_cfg;
    for (i = 0; i < PAGE_CNT_DEF; i++) begin
      refs_of[i] = (i < lo) ? REF_OUT_W'(1) : '0;
      link_of[i] = (i >= lo && i + 1 < hi) ? CFG_W'(i + 1) : NO_PAGE;
    end
    list_head = (lo < hi) ? CFG_W'(lo) : NO_PAGE;
  endfunction

  function automatic logic [PAGE_W-1:0] pop_page();
    logic [PAGE_W-1:0] p;
    p = list_head[PAGE_W-1:0];
    list_head = link_of[p];
    refs_of[p] = REF_OUT_W'(1);
    return p;
  endfunction

  // expected response for one accepted request, updating the shadow state
  function automatic rsp_t serve_request(req_t rq);
    rsp_t                 rs;
    logic [REF_OUT_W-1:0] c;
    logic [PAGE_W-1:0]    pg;
    int unsigned          k;
    pg = rq.page_index;
    rs.result_page = pg;
    rs.ref_value   = '0;
    rs.status      = ST_OK;
    case (rq.operation)
      OP_ALLOC, OP_ALLOC_MANY: begin
        rs.result_page = '0;
        if (list_head >= NO_PAGE) begin
          rs.status = ST_EMPTY;
        end else if (rq.operation == OP_ALLOC) begin
          rs.result_page = pop_page();
          rs.ref_value   = REF_OUT_W'(1);
        end else if (rq.page_count == '0) begin
          // zero pages: peek at the head only
          rs.result_page = list_head[PAGE_W-1:0];
          rs.ref_value   = refs_of[list_head[PAGE_W-1:0]];
        end else begin
          rs.result_page = list_head[PAGE_W-1:0];
          rs.ref_value   = REF_OUT_W'(1);
          for (k = 0; k < rq.page_count; k++) begin
            if (list_head >= NO_PAGE) begin
              rs.status = ST_PARTIAL;
              break;
            end
            void'(pop_page());
          end
        end
      end
      OP_FREE, OP_INC_REF, OP_DEC_REF, OP_GET_REF: begin
        c = refs_of[pg];
        // free pushes even when the count is already zero
        if (rq.operation == OP_FREE) begin
          link_of[pg] = list_head;
          list_head   = CFG_W'(pg);
        end
        if (rq.operation == OP_INC_REF) begin
          if (c != REF_CEIL) c++;
        end else if (rq.operation == OP_FREE || rq.operation == OP_DEC_REF) begin
          if (c == '0) rs.status = ST_UNDERFLOW;
          else c--;
        end
        refs_of[pg]  = c;
        rs.ref_value = c;
      end
      default: ;
    endcase
    return rs;
  endfunction

  function automatic void note_failure(string what, rsp_t exp_rsp, rsp_t got_rsp);
    mismatches++;
    if (mismatches <= MAX_SHOWN) begin
      $display("%0t: %s: expected page %0d ref %0d status %0d, got page %0d ref %0d status %0d",
               $realtime, what, exp_rsp.result_page, exp_rsp.ref_value, exp_rsp.status,
               got_rsp.result_page, got_rsp.ref_value, got_rsp.status);
    end
  endfunction

  // compare results, track register writes, predict accepted requests
  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp_rsp;
    if (!rst_ni) begin
      reserved_cfg = RESERVED_RST;
      total_cfg    = TOTAL_RST;
      rebuild_pool();
      expected_q.delete();
      pending_o    <= 0;
      fail_count_o <= mismatches;
    end else begin
      if (done_o) begin
        if (expected_q.size() == 0) begin
          note_failure("result with no request pending", '0, rsp_o);
        end else begin
          exp_rsp = expected_q.pop_front();
          if (rsp_o.result_page != exp_rsp.result_page ||
              rsp_o.ref_value != exp_rsp.ref_value ||
              rsp_o.status != exp_rsp.status) begin
            note_failure("result mismatch", exp_rsp, rsp_o);
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_RESERVED) reserved_cfg = cfg_data_i;
        else if (cfg_idx_i == CFG_TOTAL) total_cfg = cfg_data_i;
        rebuild_pool();
      end
      if (start_i && !busy_o) expected_q.push_back(serve_request(req_i));
      pending_o    <= expected_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

[test/page_frame_free_list_allocator_top_tb.sv]
`timescale 1ns / 1ps

module page_frame_free_list_allocator_top_tb;
  import pfa_pkg::*;

  // opcodes the block does not define
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int PHASE_ITEMS    = 185;
  localparam int REF_STEPS      = 40;

  logic                 clk_i      = 1'b0;
  logic                 rst_ni     = 1'b0;
  logic                 start_i    = 1'b0;
  req_t                 req_i      = '0;
  logic                 cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i  = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 busy_o;
  logic                 done_o;
  rsp_t                 rsp_o;

  int pending;
  int fail_count;
  int stall_cycles = 0;
  int sent         = 0;
  int cfg_writes   = 0;
  int idle_pct     = 0;

  page_frame_free_list_allocator_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_i      (req_i),
    .busy_o     (busy_o),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  free_list_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .req_i        (req_i),
    .busy_o       (busy_o),
    .done_o       (done_o),
    .rsp_o        (rsp_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog on cycles with no request, result or register write
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o || cfg_we_i) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: nothing accepted for %0d cycles", stall_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // hold one request until taken, then maybe leave a gap
  task automatic send_request(input logic [OP_W-1:0] op, input logic [PAGE_W-1:0] page,
                              input logic [COUNT_W-1:0] cnt);
    req_t rq;
    int   gap;
    rq.operation  = op;
    rq.page_index = page;
    rq.page_count = cnt;
    start_i <= 1'b1;
    req_i   <= rq;
    do @(posedge clk_i); while (busy_o);
    sent++;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop sending until every result is back and the block is idle
  task automatic drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (busy_o || pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_writes++;
  endtask

  // one register setting followed by random requests focused on the managed pages
  task automatic run_phase(input logic [CFG_W-1:0] res, input logic [CFG_W-1:0] tot,
                           input int pct);
    int                 span;
    int                 sel;
    int                 i;
    logic [OP_W-1:0]    op;
    logic [PAGE_W-1:0]  page;
    logic [COUNT_W-1:0] cnt;
    idle_pct = 0;
    write_reg(CFG_RESERVED, res);
    write_reg(CFG_TOTAL, tot);
    idle_pct = pct;
    span = ((tot > PAGE_CNT_DEF) ? PAGE_CNT_DEF : tot) + 4;
    if (span > PAGE_CNT_DEF) span = PAGE_CNT_DEF;
    for (i = 0; i < PHASE_ITEMS; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 24)      op = OP_ALLOC;
      else if (sel < 40) op = OP_ALLOC_MANY;
      else if (sel < 58) op = OP_FREE;
      else if (sel < 70) op = OP_INC_REF;
      else if (sel < 82) op = OP_DEC_REF;
      else if (sel < 94) op = OP_GET_REF;
      else if (sel < 97) op = OP_SPARE_6;
      else               op = OP_SPARE_7;
      page = ($urandom_range(0, 99) < 85) ? PAGE_W'($urandom_range(0, span - 1))
                                          : PAGE_W'($urandom);
      sel = $urandom_range(0, 99);
      if (sel < 70)      cnt = COUNT_W'($urandom_range(0, 4));
      else if (sel < 99) cnt = COUNT_W'($urandom_range(5, 40));
      else               cnt = COUNT_W'($urandom);
      send_request(op, page, cnt);
      if (i % 60 == 59) drain();
    end
  endtask

  initial begin
    int i;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed requests at the reset setting
    send_request(OP_GET_REF, 12'd0, '0);
    send_request(OP_GET_REF, '1, '0);
    send_request(OP_ALLOC, '0, '0);
    send_request(OP_ALLOC, '1, '1);
    send_request(OP_ALLOC_MANY, 12'd0, 13'd0);
    send_request(OP_ALLOC_MANY, 12'd0, 13'd3);
    send_request(OP_INC_REF, 12'd3, '0);
    send_request(OP_INC_REF, 12'd3, '0);
    send_request(OP_DEC_REF, 12'd4, '0);
    send_request(OP_DEC_REF, 12'd4, '0);
    // drain the whole list and run past its end
    send_request(OP_ALLOC_MANY, 12'd0, '1);
    send_request(OP_ALLOC, 12'd0, '0);
    send_request(OP_ALLOC_MANY, 12'd0, 13'd0);
    send_request(OP_ALLOC_MANY, 12'd0, 13'd5);
    send_request(OP_FREE, '1, '0);
    send_request(OP_ALLOC_MANY, 12'd0, 13'd2);
    // double free leaves a self loop in the chain
    send_request(OP_FREE, 12'd5, '0);
    send_request(OP_FREE, 12'd5, '0);
    send_request(OP_ALLOC, 12'd0, '0);
    send_request(OP_ALLOC, 12'd0, '0);
    send_request(OP_ALLOC_MANY, 12'd0, 13'd4);
    send_request(OP_GET_REF, 12'd5, '0);
    send_request(OP_SPARE_6, '1, '1);
    send_request(OP_SPARE_7, 12'd0, '0);

    // random phases across register settings and sender idling
    run_phase(13'd0, 13'd24, 0);
    run_phase(13'd2, 13'd40, 57);
    drain();
    run_phase(13'd5, 13'd12, 8);
    run_phase(13'd0, 13'd4096, 0);
    run_phase(13'd4096, 13'd4096, 57);
    run_phase('1, '1, 0);
    run_phase(13'd3, 13'd0, 8);
    run_phase(13'd0, 13'd1, 57);
    run_phase(13'd1, 13'd64, 0);
    run_phase(13'd6, 13'd30, 57);

    // walk one count up, then step it down once
    idle_pct = 0;
    for (i = 0; i < REF_STEPS; i++) send_request(OP_INC_REF, 12'd1, '0);
    send_request(OP_DEC_REF, 12'd1, '0);
    send_request(OP_GET_REF, 12'd1, '0);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d requests over %0d register writes: allocs, multi-page runs,",
             sent, cfg_writes);
    $display("list exhaustion, double free, count underflow, repeated increments, spare opcodes");
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
